// File: hdl/mp2a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mp2a_pkg
// Shared types, constants and register indexes for the 2-D max pooling block.
// -----------------------------------------------------------------------------
package mp2a_pkg;

    localparam int MaxWidthDef    = 128;
    localparam int MaxHeightDef   = 128;
    localparam int MaxChannelsDef = 32;
    localparam int MaxWindowDef   = 4;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 8;

    localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_WINDOW_WIDTH  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_WINDOW_HEIGHT = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_STEP_SIZE     = 3'd5;

    typedef struct packed {
        logic signed [15:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] max_value;
        logic [18:0]        source_offset;
        logic [7:0]         image_number;
        logic [6:0]         out_row;
        logic [6:0]         out_col;
        logic [4:0]         window_channel;
    } t_out_item;

    typedef struct packed {
        logic [CfgIdxW-1:0]  index;
        logic [CfgDataW-1:0] data;
    } t_cfg_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_UPDATE,
        ST_ADVANCE,
        ST_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic cfg_we;    // write configuration register
        logic load;      // capture sample and begin stride division
        logic div_step;  // one step of the stride division
        logic tap_read;  // issue store read for current tap
        logic tap_upd;   // compare/write current tap
        logic tap_next;  // step to next tap
        logic advance;   // advance positions
        logic emit_done; // result taken
    } t_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic div_last;  // final division step
        logic tap_last;  // current tap is the last of the window set
        logic has_result;
    } t_stat;

endpackage : mp2a_pkg
`default_nettype wire

// File: hdl/mp2a_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mp2a_if
// Valid/ready channel carrying one payload item per transaction.
// -----------------------------------------------------------------------------
interface mp2a_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : mp2a_if
`default_nettype wire

// File: hdl/mp2a_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mp2a_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// -----------------------------------------------------------------------------
module mp2a_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule : mp2a_ram
`default_nettype wire

// File: hdl/mp2a_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mp2a_ctrl
// Sequencer: walks the window taps touched by each element, then advances.
// -----------------------------------------------------------------------------
module mp2a_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire mp2a_pkg::t_stat i_stat,
    output mp2a_pkg::t_ctrl     o_ctrl
);
    import mp2a_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_ctrl      = '0;
        o_cfg_ready = 1'b0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // configuration takes priority over a waiting element
                o_cfg_ready = 1'b1;
                o_in_ready  = !i_cfg_valid;
                if (i_cfg_valid) begin
                    o_ctrl.cfg_we = 1'b1;
                end else if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                o_ctrl.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_ctrl.tap_read = 1'b1;
                n_state         = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_ctrl.tap_upd = 1'b1;
                if (i_stat.tap_last) begin
                    n_state = ST_ADVANCE;
                end else begin
                    o_ctrl.tap_next = 1'b1;
                    n_state         = ST_READ;
                end
            end
            ST_ADVANCE: begin
                o_ctrl.advance = 1'b1;
                n_state = i_stat.has_result ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_ctrl.emit_done = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule : mp2a_ctrl
`default_nettype wire

// File: hdl/mp2a_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mp2a_dp
// Datapath: configuration, positions, partial-maximum stores and result.
// -----------------------------------------------------------------------------
module mp2a_dp #(
    parameter int MAX_WIDTH    = mp2a_pkg::MaxWidthDef,
    parameter int MAX_HEIGHT   = mp2a_pkg::MaxHeightDef,
    parameter int MAX_CHANNELS = mp2a_pkg::MaxChannelsDef,
    parameter int MAX_WINDOW   = mp2a_pkg::MaxWindowDef
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire mp2a_pkg::t_cfg_item i_cfg,
    input  wire mp2a_pkg::t_in_item  i_in,
    input  wire mp2a_pkg::t_ctrl     i_ctrl,
    output mp2a_pkg::t_stat          o_stat,
    output mp2a_pkg::t_out_item      o_out
);
    import mp2a_pkg::*;

    localparam int WinBits = $clog2(MAX_WINDOW);
    localparam int WinW    = $clog2(MAX_WINDOW + 1);
    localparam int ColW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RowW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ChW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SlotW   = WinBits + ColW + ChW;
    localparam int Depth   = (1 << SlotW);
    localparam int DivW    = (RowW > ColW) ? RowW : ColW;
    localparam int CntW    = (DivW > 1) ? $clog2(DivW) : 1;

    // configuration registers
    logic [7:0] r_img_w, r_img_h;
    logic [5:0] r_ch_cnt;
    logic [2:0] r_win_w, r_win_h, r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= 8'd2;
            r_img_h  <= 8'd2;
            r_ch_cnt <= 6'd1;
            r_win_w  <= 3'd2;
            r_win_h  <= 3'd2;
            r_step   <= 3'd2;
        end else if (i_ctrl.cfg_we) begin
            unique case (i_cfg.index)
                REG_IMAGE_WIDTH:   r_img_w  <= i_cfg.data;
                REG_IMAGE_HEIGHT:  r_img_h  <= i_cfg.data;
                REG_CHANNEL_COUNT: r_ch_cnt <= i_cfg.data[5:0];
                REG_WINDOW_WIDTH:  r_win_w  <= i_cfg.data[2:0];
                REG_WINDOW_HEIGHT: r_win_h  <= i_cfg.data[2:0];
                REG_STEP_SIZE:     r_step   <= i_cfg.data[2:0];
                default: ;
            endcase
        end
    end

    // saturate registers to legal ranges
    function automatic logic [31:0] clampv(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] res;
        res = v;
        if (v < 32'd1) res = 32'd1;
        else if (v > hi) res = hi;
        return res;
    endfunction

    logic [31:0] w_w, w_h, w_c, w_fw, w_fh, w_s;
    assign w_w  = clampv(32'(r_img_w), 32'(MAX_WIDTH));
    assign w_h  = clampv(32'(r_img_h), 32'(MAX_HEIGHT));
    assign w_c  = clampv(32'(r_ch_cnt), 32'(MAX_CHANNELS));
    assign w_fw = clampv(32'(r_win_w), 32'(MAX_WINDOW));
    assign w_fh = clampv(32'(r_win_h), 32'(MAX_WINDOW));
    assign w_s  = clampv(32'(r_step), 32'(MAX_WINDOW));

    // positions
    logic [RowW-1:0] r_row;
    logic [ColW-1:0] r_col;
    logic [ChW-1:0]  r_ch;
    logic [7:0]      r_img;

    // sample and scan state
    logic signed [15:0] r_val;
    logic [18:0]        r_off;
    logic [RowW+7:0]    r_prod_rw;  // row*W
    logic [ColW+5:0]    r_prod_cc;  // col*C
    logic [WinW-1:0]    r_dy, r_dx;
    logic               r_hit;
    logic [SlotW-1:0]   r_slot;
    logic [RowW-1:0]    r_i;
    logic [ColW-1:0]    r_j;
    logic               r_first, r_lastw;
    logic               r_res;
    t_out_item          r_out;

    // stride division: row and column by stride, one quotient bit per step;
    // afterwards the row pair tracks (row - dy) and a copy of the column pair
    // tracks (col - dx) as the taps are walked
    logic [DivW-1:0] r_rq, r_cq, r_tq_col;
    logic [WinW-1:0] r_rr, r_cr, r_tr_col;
    logic [CntW-1:0] r_div_cnt;

    logic [WinW:0]   w_sd, w_rt, w_ct;
    logic            w_rge, w_cge;
    logic [WinW-1:0] n_rr, n_cr;
    logic [DivW-1:0] n_rq, n_cq;
    always_comb begin
        w_sd  = (WinW+1)'(w_s);
        w_rt  = {r_rr, r_rq[DivW-1]};
        w_ct  = {r_cr, r_cq[DivW-1]};
        w_rge = (w_rt >= w_sd);
        w_cge = (w_ct >= w_sd);
        n_rr  = w_rge ? WinW'(w_rt - w_sd) : WinW'(w_rt);
        n_cr  = w_cge ? WinW'(w_ct - w_sd) : WinW'(w_ct);
        n_rq  = {r_rq[DivW-2:0], w_rge};
        n_cq  = {r_cq[DivW-2:0], w_cge};
    end

    // element offset from the current geometry
    logic [31:0] w_off_full;
    assign w_off_full = 32'(r_prod_rw) * 32'(w_c[5:0]) + 32'(r_prod_cc) + 32'(r_ch);

    // tap hit and store slot
    logic             w_rok, w_cok;
    logic [SlotW-1:0] w_slot;
    assign w_rok  = (32'(r_row) >= 32'(r_dy)) && (r_rr == '0);
    assign w_cok  = (32'(r_col) >= 32'(r_dx)) && (r_tr_col == '0);
    assign w_slot = {WinBits'(r_rq), ColW'(r_tq_col), r_ch};

    // stores
    logic        w_we;
    logic [15:0] w_rmax;
    logic [18:0] w_roff;
    logic signed [15:0] w_wmax;
    logic [18:0] w_woff;

    mp2a_ram #(.WIDTH(16), .DEPTH(Depth)) u_max_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_slot), .i_wdata(w_wmax),
        .i_raddr(w_slot), .o_rdata(w_rmax)
    );
    mp2a_ram #(.WIDTH(19), .DEPTH(Depth)) u_off_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_slot), .i_wdata(w_woff),
        .i_raddr(w_slot), .o_rdata(w_roff)
    );

    // update decision for current tap
    logic w_take;
    assign w_take = r_first || (r_val > $signed(w_rmax));
    assign w_we   = i_ctrl.tap_upd && r_hit && w_take;
    assign w_wmax = r_val;
    assign w_woff = r_off;

    logic w_last_tap;
    assign w_last_tap = (32'(r_dy) == w_fh - 32'd1) && (32'(r_dx) == w_fw - 32'd1);
    assign o_stat.div_last   = (r_div_cnt == CntW'(DivW - 1));
    assign o_stat.tap_last   = w_last_tap;
    assign o_stat.has_result = r_res;
    assign o_out = r_out;

    // scan and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0; r_col <= '0; r_ch <= '0; r_img <= '0;
            r_res <= 1'b0;
        end else begin
            if (i_ctrl.load) begin
                r_val     <= i_in.sample_value;
                r_prod_rw <= (RowW+8)'(r_row) * (RowW+8)'(w_w[7:0]);
                r_prod_cc <= (ColW+6)'(r_col) * (ColW+6)'(w_c[5:0]);
                r_rq      <= DivW'(r_row);
                r_cq      <= DivW'(r_col);
                r_rr      <= '0;
                r_cr      <= '0;
                r_div_cnt <= '0;
                r_dy      <= '0;
                r_dx      <= '0;
                r_res     <= 1'b0;
            end
            if (i_ctrl.div_step) begin
                r_rq      <= n_rq;
                r_rr      <= n_rr;
                r_cq      <= n_cq;
                r_cr      <= n_cr;
                r_tq_col  <= n_cq;
                r_tr_col  <= n_cr;
                r_div_cnt <= r_div_cnt + 1'b1;
                r_off     <= w_off_full[18:0];
            end
            if (i_ctrl.tap_read) begin
                r_hit   <= w_rok && w_cok;
                r_i     <= RowW'(r_rq);
                r_j     <= ColW'(r_tq_col);
                r_first <= (r_dy == '0) && (r_dx == '0);
                r_lastw <= w_last_tap;
                r_slot  <= w_slot;
            end
            if (i_ctrl.tap_upd && r_hit && r_lastw) begin
                r_res <= 1'b1;
                r_out.max_value      <= w_take ? r_val : $signed(w_rmax);
                r_out.source_offset  <= w_take ? r_off : w_roff;
                r_out.image_number   <= r_img;
                r_out.out_row        <= 7'(r_i);
                r_out.out_col        <= 7'(r_j);
                r_out.window_channel <= 5'(r_ch);
            end
            if (i_ctrl.tap_next) begin
                if (32'(r_dx) == w_fw - 32'd1) begin
                    // next tap row: step the row pair down, restart the column pair
                    r_dx     <= '0;
                    r_dy     <= r_dy + 1'b1;
                    r_tq_col <= r_cq;
                    r_tr_col <= r_cr;
                    if (r_rr == '0) begin
                        r_rr <= WinW'(w_s - 32'd1);
                        r_rq <= r_rq - 1'b1;
                    end else begin
                        r_rr <= r_rr - 1'b1;
                    end
                end else begin
                    r_dx <= r_dx + 1'b1;
                    if (r_tr_col == '0) begin
                        r_tr_col <= WinW'(w_s - 32'd1);
                        r_tq_col <= r_tq_col - 1'b1;
                    end else begin
                        r_tr_col <= r_tr_col - 1'b1;
                    end
                end
            end
            if (i_ctrl.advance) begin
                if (32'(r_ch) + 32'd1 >= w_c) begin
                    r_ch <= '0;
                    if (32'(r_col) + 32'd1 >= w_w) begin
                        r_col <= '0;
                        if (32'(r_row) + 32'd1 >= w_h) begin
                            r_row <= '0;
                            r_img <= r_img + 8'd1;
                        end else begin
                            r_row <= r_row + 1'b1;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end else begin
                    r_ch <= r_ch + 1'b1;
                end
            end
            if (i_ctrl.emit_done) begin
                r_res <= 1'b0;
            end
        end
    end
endmodule : mp2a_dp
`default_nettype wire

// File: hdl/max_pool_2d_argmax.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// max_pool_2d_argmax
// Streaming 2-D max pooling with argmax over raster-ordered Q8.8 elements.
// -----------------------------------------------------------------------------
//  channel  dir  payload                         handshake
//  s_in     in   sample_value                    valid/ready
//  m_out    out  max_value..window_channel       valid/ready
//  s_cfg    in   index, data                     valid/ready
//
//  An element passes through accept, the stride division and offset, a
//  read-then-update pass over the store RAMs for each window tap, and an
//  advance; a completed window then offers its result until it is taken.
//  Reset is synchronous; the stores need no clearing.
//  Input is held off while a result waits; a register write, taken only when
//  idle, holds input off for that cycle.
// -----------------------------------------------------------------------------
module max_pool_2d_argmax #(
    parameter int MAX_WIDTH    = mp2a_pkg::MaxWidthDef,
    parameter int MAX_HEIGHT   = mp2a_pkg::MaxHeightDef,
    parameter int MAX_CHANNELS = mp2a_pkg::MaxChannelsDef,
    parameter int MAX_WINDOW   = mp2a_pkg::MaxWindowDef
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    mp2a_if.sink     s_in,
    mp2a_if.source   m_out,
    mp2a_if.sink     s_cfg
);
    import mp2a_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;

    // sequencer
    mp2a_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(s_cfg.valid), .o_cfg_ready(s_cfg.ready),
        .i_in_valid(s_in.valid), .o_in_ready(s_in.ready),
        .o_out_valid(m_out.valid), .i_out_ready(m_out.ready),
        .i_stat(w_stat), .o_ctrl(w_ctrl)
    );

    // datapath
    mp2a_dp #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_CHANNELS(MAX_CHANNELS), .MAX_WINDOW(MAX_WINDOW)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg(s_cfg.data),
        .i_in(s_in.data), .i_ctrl(w_ctrl), .o_stat(w_stat), .o_out(m_out.data)
    );
endmodule : max_pool_2d_argmax
`default_nettype wire

// File: hdl/mp2a_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mp2a_chk
// Port-level checks for the pooling block, bound to the top level.
// -----------------------------------------------------------------------------
module mp2a_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic [63:0] i_out_data
);
    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed under stall");

    // no input taken while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while result pending");

    // an accepted element is not followed at once by another
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("back-to-back accept");

    // a result never shows in the cycle after accepting
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_out_valid)
        else $error("result too early");
endmodule : mp2a_chk

bind max_pool_2d_argmax mp2a_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(s_in.valid), .i_in_ready(s_in.ready),
    .i_out_valid(m_out.valid), .i_out_ready(m_out.ready),
    .i_out_data(64'(m_out.data))
);
`default_nettype wire

// File: verif/max_pool_2d_argmax_test.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// max_pool_2d_argmax_test
// Self-checking bench for the 2-D max pooling block. Whole images of random
// and edge-case Q8.8 elements are streamed under many register settings. Each
// transaction is run through a local window-maximum predictor, and every
// result is checked field by field against the oldest pending expectation.
// -----------------------------------------------------------------------------
module max_pool_2d_argmax_test;
    import mp2a_pkg::*;

    localparam int StoreDepth = MaxWindowDef * MaxWidthDef * MaxChannelsDef;
    localparam int SettleCycles = 60;
    localparam int RandomItems = 1750;

    logic i_clk;
    logic i_rst_n;

    mp2a_if #(.T(t_in_item))  in_if ();
    mp2a_if #(.T(t_out_item)) out_if ();
    mp2a_if #(.T(t_cfg_item)) cfg_if ();

    max_pool_2d_argmax u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_in   (in_if),
        .m_out  (out_if),
        .s_cfg  (cfg_if)
    );

    // Predictor state: raw registers, window stores, positions
    int unsigned reg_w, reg_h, reg_c, reg_fw, reg_fh, reg_step;
    int          win_max [StoreDepth];
    int unsigned win_off [StoreDepth];
    int unsigned pos_row, pos_col, pos_ch, img_count;

    t_out_item   pending_results[$];
    int          error_count;
    int          sample_count;
    int          rx_hold;
    int          rx_stall;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int unsigned sat(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Run one element through the window maxima; return 1 on a completed window
    function automatic bit pool_predict(logic signed [15:0] v, output t_out_item res);
        int unsigned w, h, c, fw, fh, s, off, i, j, slot;
        bit          produced;
        w  = sat(reg_w, MaxWidthDef);
        h  = sat(reg_h, MaxHeightDef);
        c  = sat(reg_c, MaxChannelsDef);
        fw = sat(reg_fw, MaxWindowDef);
        fh = sat(reg_fh, MaxWindowDef);
        s  = sat(reg_step, MaxWindowDef);
        off = (pos_row * w * c + pos_col * c + pos_ch) & 32'h7FFFF;
        produced = 1'b0;
        res = '0;
        for (int unsigned dy = 0; dy < fh; dy++) begin
            if (pos_row < dy || (pos_row - dy) % s != 0) continue;
            i = (pos_row - dy) / s;
            for (int unsigned dx = 0; dx < fw; dx++) begin
                if (pos_col < dx || (pos_col - dx) % s != 0) continue;
                j = (pos_col - dx) / s;
                slot = ((i % MaxWindowDef) * MaxWidthDef + (j % MaxWidthDef))
                       * MaxChannelsDef + (pos_ch % MaxChannelsDef);
                // first element of a window always takes it; ties keep the older one
                if ((dy == 0 && dx == 0) || int'(v) > win_max[slot]) begin
                    win_max[slot] = int'(v);
                    win_off[slot] = off;
                end
                if (dy == fh - 1 && dx == fw - 1) begin
                    res.max_value      = win_max[slot][15:0];
                    res.source_offset  = win_off[slot][18:0];
                    res.image_number   = img_count[7:0];
                    res.out_row        = i[6:0];
                    res.out_col        = j[6:0];
                    res.window_channel = pos_ch[4:0];
                    produced = 1'b1;
                end
            end
        end
        // advance raster position
        if (pos_ch + 1 >= c) begin
            pos_ch = 0;
            if (pos_col + 1 >= w) begin
                pos_col = 0;
                if (pos_row + 1 >= h) begin
                    pos_row = 0;
                    img_count = (img_count + 1) & 8'hFF;
                end else begin
                    pos_row++;
                end
            end else begin
                pos_col++;
            end
        end else begin
            pos_ch++;
        end
        return produced;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [15:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'sh7FFF;
        if (r < 20) return 16'sh8000;
        if (r < 40) return 16'(signed'($urandom_range(0, 8)) - 4);
        return 16'($urandom);
    endfunction

    // Send one element and record its expectation at acceptance
    task automatic send_sample(logic signed [15:0] v);
        int        gap;
        t_out_item res;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= v;
        do @(negedge i_clk); while (!in_if.ready);
        if (pool_predict(v, res)) pending_results.push_back(res);
        sample_count++;
        @(posedge i_clk);
    endtask

    // Write one register; the channel is released before returning
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: idx, data: val};
        do @(negedge i_clk); while (!cfg_if.ready);
        case (idx)
            REG_IMAGE_WIDTH:   reg_w    = 32'(val);
            REG_IMAGE_HEIGHT:  reg_h    = 32'(val);
            REG_CHANNEL_COUNT: reg_c    = 32'(val & 8'h3F);
            REG_WINDOW_WIDTH:  reg_fw   = 32'(val & 8'h07);
            REG_WINDOW_HEIGHT: reg_fh   = 32'(val & 8'h07);
            REG_STEP_SIZE:     reg_step = 32'(val & 8'h07);
            default: ;
        endcase
        @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop the input valid and wait for the block to drain
    task automatic settle();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic set_geometry(int w, int h, int c, int fw, int fh, int s);
        settle();
        write_reg(REG_IMAGE_WIDTH, CfgDataW'(w));
        write_reg(REG_IMAGE_HEIGHT, CfgDataW'(h));
        write_reg(REG_CHANNEL_COUNT, CfgDataW'(c));
        write_reg(REG_WINDOW_WIDTH, CfgDataW'(fw));
        write_reg(REG_WINDOW_HEIGHT, CfgDataW'(fh));
        write_reg(REG_STEP_SIZE, CfgDataW'(s));
    endtask

    function automatic int image_size();
        return sat(reg_w, MaxWidthDef) * sat(reg_h, MaxHeightDef)
               * sat(reg_c, MaxChannelsDef);
    endfunction

    task automatic send_image();
        int n;
        n = image_size();
        for (int k = 0; k < n; k++) send_sample(pick_sample());
    endtask

    // Reset settings: one 2x2 image of extremes, then one of equal values
    task automatic test_reset_settings();
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh0000);
        repeat (4) send_sample(-16'sd5);
    endtask

    // Saturated registers, oversize windows, overlap and ignored indexes
    task automatic test_register_edges();
        set_geometry(0, 0, 0, 0, 0, 0);
        send_sample(16'sh1234);
        set_geometry(8'hFF, 1, 1, 7, 1, 7);
        send_image();
        set_geometry(3, 3, 2, 4, 4, 1);
        send_image();
        set_geometry(2, 5, 8'hFF, 4, 2, 1);
        send_image();
        settle();
        write_reg(3'd6, 8'hA5);
        write_reg(3'd7, 8'h5A);
        set_geometry(4, 4, 1, 1, 1, 3);
        send_image();
    endtask

    // Random geometries with whole images of random content
    task automatic test_random_images();
        int r, w, h, c;
        while (sample_count < RandomItems) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                w = $urandom_range(128, 255); h = 1; c = 1;
            end else if (r < 10) begin
                w = 2; h = 2; c = $urandom_range(32, 63);
            end else if (r < 13) begin
                w = 1; h = 128; c = 1;
            end else begin
                w = $urandom_range(1, 9); h = $urandom_range(1, 9);
                c = $urandom_range(1, 3);
            end
            set_geometry(w, h, c, $urandom_range(1, 4), $urandom_range(1, 4),
                         $urandom_range(1, 4));
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 9) == 0) begin
                    // pause mid-image until every result is in
                    for (int k = 0; k < image_size(); k++) begin
                        if (k == image_size() / 2) settle();
                        if (sample_count < RandomItems) send_sample(pick_sample());
                    end
                end else begin
                    for (int k = 0; k < image_size(); k++) begin
                        if (sample_count < RandomItems) send_sample(pick_sample());
                    end
                end
            end
        end
    endtask

    // Hold the receiver off while the sender keeps offering
    task automatic test_backpressure();
        set_geometry(4, 4, 2, 2, 2, 1);
        rx_hold = 400;
        repeat (2) send_image();
    endtask

    // Result receiver: random stalls, plus a long hold on request
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            out_if.ready <= 1'b0;
            rx_hold--;
        end else if (rx_stall > 0) begin
            out_if.ready <= 1'b0;
            rx_stall--;
        end else begin
            out_if.ready <= 1'b1;
            if ($urandom_range(0, 99) < 25) rx_stall = pick_gap();
        end
    end

    // Check each result transaction against the oldest expectation
    always @(negedge i_clk) begin
        t_out_item got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (pending_results.size() == 0) begin
                $error("unexpected result %p", got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.max_value !== want.max_value) begin
                    $error("max_value: expected %0d, got %0d", want.max_value, got.max_value);
                    error_count++;
                end
                if (got.source_offset !== want.source_offset) begin
                    $error("source_offset: expected %0d, got %0d",
                           want.source_offset, got.source_offset);
                    error_count++;
                end
                if (got.image_number !== want.image_number) begin
                    $error("image_number: expected %0d, got %0d",
                           want.image_number, got.image_number);
                    error_count++;
                end
                if (got.out_row !== want.out_row) begin
                    $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
                    error_count++;
                end
                if (got.out_col !== want.out_col) begin
                    $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
                    error_count++;
                end
                if (got.window_channel !== want.window_channel) begin
                    $error("window_channel: expected %0d, got %0d",
                           want.window_channel, got.window_channel);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        out_if.ready = 1'b0;
        rx_hold = 0;
        rx_stall = 0;
        error_count = 0;
        sample_count = 0;
        reg_w = 2; reg_h = 2; reg_c = 1; reg_fw = 2; reg_fh = 2; reg_step = 2;
        pos_row = 0; pos_col = 0; pos_ch = 0; img_count = 0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_settings();
        test_register_edges();
        test_backpressure();
        test_random_images();

        settle();
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule : max_pool_2d_argmax_test
